@@ sv/tfn_pkg.sv @@
// Package for the triangle face normal block: widths, the side-band and
// cell structs, and the bit-length function. Depends on nothing else.
package tfn_pkg;

   localparam int COORD_WIDTH          = 24;
   localparam int NORMAL_FRACTION_BITS = 14;
   localparam int NORM_BITS            = 30;
   localparam int RECIP_SHIFT          = 62;

   localparam int EDGE_W    = COORD_WIDTH + 1;
   localparam int PROD_W    = 2 * EDGE_W;
   localparam int CROSS_W   = PROD_W + 1;
   localparam int MAG_W     = PROD_W;
   localparam int LEN_W     = $clog2(MAG_W + 1);
   localparam int SMALL_W   = 16;
   localparam int SQ_SUM_W  = 2 * SMALL_W + 2;
   localparam int LIMIT_W   = 32;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(281);

   localparam int RAD_W     = 2 * NORM_BITS + 2;
   localparam int ROOT_W    = NORM_BITS + 1;
   localparam int REM_W     = ROOT_W + 2;
   localparam int INV_W     = RECIP_SHIFT - NORM_BITS + 2;
   localparam int MUL_W     = NORM_BITS + INV_W;
   localparam int OUT_SHIFT = RECIP_SHIFT - NORMAL_FRACTION_BITS;
   localparam int OUT_W     = 16;
   localparam int UNIT      = 1 << NORMAL_FRACTION_BITS;

   // Data that rides alongside the square root and reciprocal cells.
   typedef struct packed {
      logic [2:0][NORM_BITS-1:0] c;
      logic [2:0]                neg;
      logic                      degenerate;
   } tfn_side_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } tfn_sqrt_type;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [ROOT_W-1:0] divisor;
      logic [INV_W-1:0]  quot;
   } tfn_recip_type;

   // Bit length of a magnitude: one more than the index of its top set bit.
   function automatic logic [LEN_W-1:0] tfn_bitlen(input logic [MAG_W-1:0] v);
      logic [LEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            n = LEN_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

@@ sv/tfn_sqrt_cell.sv @@
// One cell of the integer square root chain: settles one root bit per beat.
// Depends on tfn_pkg.
module tfn_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tfn_pkg::tfn_side_type in_side,
   input  tfn_pkg::tfn_sqrt_type in_work,
   output logic                  out_valid,
   output tfn_pkg::tfn_side_type out_side,
   output tfn_pkg::tfn_sqrt_type out_work
);

   logic                  valid_ff;
   tfn_pkg::tfn_side_type side_ff;
   tfn_pkg::tfn_sqrt_type work_ff, work_in;
   logic [tfn_pkg::REM_W+1:0] rem_sh;
   logic [tfn_pkg::REM_W+1:0] trial;
   logic                      take;

   always_comb begin
      rem_sh = {in_work.rem, in_work.rad[tfn_pkg::RAD_W-1 -: 2]};
      trial  = (tfn_pkg::REM_W+2)'({in_work.root, 2'b01});
      take   = (rem_sh >= trial);
      work_in.rad  = {in_work.rad[tfn_pkg::RAD_W-3:0], 2'b00};
      work_in.rem  = take ? tfn_pkg::REM_W'(rem_sh - trial) : tfn_pkg::REM_W'(rem_sh);
      work_in.root = {in_work.root[tfn_pkg::ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_work  = work_ff;

endmodule

@@ sv/tfn_recip_cell.sv @@
// One cell of the reciprocal chain: restoring division, one quotient bit
// per beat. Depends on tfn_pkg.
module tfn_recip_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tfn_pkg::tfn_side_type  in_side,
   input  tfn_pkg::tfn_recip_type in_work,
   output logic                   out_valid,
   output tfn_pkg::tfn_side_type  out_side,
   output tfn_pkg::tfn_recip_type out_work
);

   logic                   valid_ff;
   tfn_pkg::tfn_side_type  side_ff;
   tfn_pkg::tfn_recip_type work_ff, work_in;
   logic [tfn_pkg::ROOT_W:0] rem2;
   logic [tfn_pkg::ROOT_W:0] dvs;
   logic                     take;

   always_comb begin
      rem2 = {in_work.rem, 1'b0};
      dvs  = {1'b0, in_work.divisor};
      take = (rem2 >= dvs);
      work_in.divisor = in_work.divisor;
      work_in.rem     = take ? tfn_pkg::ROOT_W'(rem2 - dvs) : tfn_pkg::ROOT_W'(rem2);
      work_in.quot    = {in_work.quot[tfn_pkg::INV_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_work  = work_ff;

endmodule

@@ sv/triangle_face_normal_top.sv @@
// Top level of the triangle face normal block: front pipeline, square root
// and reciprocal cell chains, and output scaling. Depends on tfn_pkg and
// on tfn_sqrt_cell and tfn_recip_cell.
//
//   channel   ports                          handshake
//   request   start, busy, req_*             beat taken when start && !busy
//   response  rsp_valid, rsp_*               one-cycle strobe, cannot stall
//   register  csr_wr_en, csr_wr_data         written when csr_wr_en is high
//
// A new triangle may be started on every clock; busy is always low.
// Each beat passes from start to rsp_valid through eight front stages,
// 31 square root cells (one root bit each), 34 reciprocal cells (one
// quotient bit each) and two output stages.
// Reset is synchronous and active high; it clears the valid bits of every
// stage and returns the degenerate limit to 281.
// The response side cannot stall, so no beat is ever held back.
module triangle_face_normal_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_first_x,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_first_y,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_first_z,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_second_x,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_second_y,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_second_z,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_third_x,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_third_y,
   input  logic signed [tfn_pkg::COORD_WIDTH-1:0]  req_third_z,
   input  logic                                    csr_wr_en,
   input  logic        [tfn_pkg::LIMIT_W-1:0]      csr_wr_data,
   output logic                                    rsp_valid,
   output logic signed [tfn_pkg::OUT_W-1:0]        rsp_normal_x,
   output logic signed [tfn_pkg::OUT_W-1:0]        rsp_normal_y,
   output logic signed [tfn_pkg::OUT_W-1:0]        rsp_normal_z,
   output logic                                    rsp_degenerate
);

   localparam int CW  = tfn_pkg::COORD_WIDTH;
   localparam int EW  = tfn_pkg::EDGE_W;
   localparam int PW  = tfn_pkg::PROD_W;
   localparam int NW  = tfn_pkg::CROSS_W;
   localparam int MW  = tfn_pkg::MAG_W;
   localparam int NB  = tfn_pkg::NORM_BITS;
   localparam int SMW = tfn_pkg::SMALL_W;
   localparam int SQ_STEPS = tfn_pkg::ROOT_W;
   localparam int RC_STEPS = tfn_pkg::INV_W;

   // The block never refuses a beat.
   assign busy = 1'b0;

   // Degenerate limit register.
   logic [tfn_pkg::LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= tfn_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Valid bits of the eight front stages.
   logic [8:1] v_ff, v_in;

   always_comb begin
      v_in = {v_ff[7:1], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage 1: edge vectors a = v2 - v1 and b = v3 - v1, indexed x, y, z.
   logic signed [EW-1:0] a_ff [3];
   logic signed [EW-1:0] b_ff [3];
   logic signed [EW-1:0] a_in [3];
   logic signed [EW-1:0] b_in [3];

   always_comb begin
      a_in[0] = {req_second_x[CW-1], req_second_x} - {req_first_x[CW-1], req_first_x};
      a_in[1] = {req_second_y[CW-1], req_second_y} - {req_first_y[CW-1], req_first_y};
      a_in[2] = {req_second_z[CW-1], req_second_z} - {req_first_z[CW-1], req_first_z};
      b_in[0] = {req_third_x[CW-1], req_third_x} - {req_first_x[CW-1], req_first_x};
      b_in[1] = {req_third_y[CW-1], req_third_y} - {req_first_y[CW-1], req_first_y};
      b_in[2] = {req_third_z[CW-1], req_third_z} - {req_first_z[CW-1], req_first_z};
   end

   // Stage 2: the six products of the cross product, p minus q per axis.
   logic signed [PW-1:0] p_ff [3];
   logic signed [PW-1:0] q_ff [3];
   logic signed [PW-1:0] p_in [3];
   logic signed [PW-1:0] q_in [3];

   always_comb begin
      p_in[0] = a_ff[1] * b_ff[2];
      q_in[0] = a_ff[2] * b_ff[1];
      p_in[1] = a_ff[2] * b_ff[0];
      q_in[1] = a_ff[0] * b_ff[2];
      p_in[2] = a_ff[0] * b_ff[1];
      q_in[2] = a_ff[1] * b_ff[0];
   end

   // Stage 3: exact cross product components.
   logic [NW-1:0] n_ff [3];
   logic [NW-1:0] n_in [3];

   // Stage 4: sign, magnitude, smallness test and squares of small parts.
   logic [MW-1:0]      mag_ff [3];
   logic [MW-1:0]      mag_in [3];
   logic [2:0]         neg4_ff, neg4_in;
   logic [2:0]         big_ff, big_in;
   logic [2*SMW-1:0]   ssq_ff [3];
   logic [2*SMW-1:0]   ssq_in [3];
   logic [NW-1:0]      nabs [3];

   // Stage 5: degenerate decision and the common bit length.
   logic [MW-1:0]            mag5_ff [3];
   logic [2:0]               neg5_ff;
   logic                     deg5_ff, deg5_in;
   logic [tfn_pkg::LEN_W-1:0] len5_ff, len5_in;
   logic [tfn_pkg::SQ_SUM_W-1:0] small_sum;

   // Stage 6: magnitudes normalised so the largest has NB bits.
   logic [NB-1:0]      c6_ff [3];
   logic [NB-1:0]      c6_in [3];
   logic [2:0]         neg6_ff;
   logic               deg6_ff;
   logic [MW+NB-1:0]   ext [3];

   // Stage 7: squares of the normalised components.
   logic [2*NB-1:0]    csq_ff [3];
   logic [2*NB-1:0]    csq_in [3];
   logic [NB-1:0]      c7_ff [3];
   logic [2:0]         neg7_ff;
   logic               deg7_ff;

   // Stage 8: radicand for the square root chain.
   logic [tfn_pkg::RAD_W-1:0] rad8_ff, rad8_in;
   tfn_pkg::tfn_side_type     side8_ff, side8_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i]   = {p_ff[i][PW-1], p_ff[i]} - {q_ff[i][PW-1], q_ff[i]};
         neg4_in[i] = n_ff[i][NW-1];
         nabs[i]   = n_ff[i][NW-1] ? (NW'(0) - n_ff[i]) : n_ff[i];
         mag_in[i] = nabs[i][MW-1:0];
         big_in[i] = (nabs[i][NW-1:SMW] != '0);
         ssq_in[i] = nabs[i][SMW-1:0] * nabs[i][SMW-1:0];
      end
      small_sum = tfn_pkg::SQ_SUM_W'(ssq_ff[0]) + tfn_pkg::SQ_SUM_W'(ssq_ff[1])
                + tfn_pkg::SQ_SUM_W'(ssq_ff[2]);
      deg5_in   = (big_ff == 3'b000)
                && (small_sum <= tfn_pkg::SQ_SUM_W'(limit_ff));
      len5_in   = tfn_pkg::tfn_bitlen(mag_ff[0] | mag_ff[1] | mag_ff[2]);
      for (int i = 0; i < 3; i++) begin
         // Scaling by 2^NB and then dropping len bits covers both the
         // left and the right normalising shift in one step.
         ext[i]    = {mag5_ff[i], NB'(0)} >> len5_ff;
         c6_in[i]  = ext[i][NB-1:0];
         csq_in[i] = c6_ff[i] * c6_ff[i];
      end
      rad8_in = tfn_pkg::RAD_W'(csq_ff[0]) + tfn_pkg::RAD_W'(csq_ff[1])
              + tfn_pkg::RAD_W'(csq_ff[2]);
      for (int i = 0; i < 3; i++) begin
         side8_in.c[i] = c7_ff[i];
      end
      side8_in.neg        = neg7_ff;
      side8_in.degenerate = deg7_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_ff[i]    <= a_in[i];
         b_ff[i]    <= b_in[i];
         p_ff[i]    <= p_in[i];
         q_ff[i]    <= q_in[i];
         n_ff[i]    <= n_in[i];
         mag_ff[i]  <= mag_in[i];
         ssq_ff[i]  <= ssq_in[i];
         mag5_ff[i] <= mag_ff[i];
         c6_ff[i]   <= c6_in[i];
         csq_ff[i]  <= csq_in[i];
         c7_ff[i]   <= c6_ff[i];
      end
      neg4_ff  <= neg4_in;
      big_ff   <= big_in;
      neg5_ff  <= neg4_ff;
      deg5_ff  <= deg5_in;
      len5_ff  <= len5_in;
      neg6_ff  <= neg5_ff;
      deg6_ff  <= deg5_ff;
      neg7_ff  <= neg6_ff;
      deg7_ff  <= deg6_ff;
      rad8_ff  <= rad8_in;
      side8_ff <= side8_in;
   end

   // Square root chain: one root bit per cell, most significant first.
   logic                  sq_valid [SQ_STEPS+1];
   tfn_pkg::tfn_side_type sq_side  [SQ_STEPS+1];
   tfn_pkg::tfn_sqrt_type sq_work  [SQ_STEPS+1];

   assign sq_valid[0]     = v_ff[8];
   assign sq_side[0]      = side8_ff;
   assign sq_work[0].rad  = rad8_ff;
   assign sq_work[0].rem  = '0;
   assign sq_work[0].root = '0;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      tfn_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_side   (sq_side[k]),
         .in_work   (sq_work[k]),
         .out_valid (sq_valid[k+1]),
         .out_side  (sq_side[k+1]),
         .out_work  (sq_work[k+1])
      );
   end

   // Reciprocal chain: floor(2^62 / root). The quotient never exceeds
   // INV_W bits, so the chain starts from the dividend's upper part.
   logic                   rc_valid [RC_STEPS+1];
   tfn_pkg::tfn_side_type  rc_side  [RC_STEPS+1];
   tfn_pkg::tfn_recip_type rc_work  [RC_STEPS+1];

   assign rc_valid[0]        = sq_valid[SQ_STEPS];
   assign rc_side[0]         = sq_side[SQ_STEPS];
   assign rc_work[0].divisor = sq_work[SQ_STEPS].root;
   assign rc_work[0].rem     = tfn_pkg::ROOT_W'(1) << (tfn_pkg::RECIP_SHIFT - tfn_pkg::INV_W);
   assign rc_work[0].quot    = '0;

   for (genvar k = 0; k < RC_STEPS; k++) begin : g_recip
      tfn_recip_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rc_valid[k]),
         .in_side   (rc_side[k]),
         .in_work   (rc_work[k]),
         .out_valid (rc_valid[k+1]),
         .out_side  (rc_side[k+1]),
         .out_work  (rc_work[k+1])
      );
   end

   // Output stage A: each normalised component times the reciprocal.
   logic                      mv_ff;
   logic [tfn_pkg::MUL_W-1:0] prod_ff [3];
   logic [tfn_pkg::MUL_W-1:0] prod_in [3];
   logic [2:0]                negm_ff;
   logic                      degm_ff;

   // Output stage B: round, apply the sign and force zero when degenerate.
   logic                      rsp_valid_ff;
   logic [tfn_pkg::OUT_W-1:0] rsp_n_ff [3];
   logic [tfn_pkg::OUT_W-1:0] rsp_n_in [3];
   logic                      rsp_deg_ff;
   logic [tfn_pkg::MUL_W:0]   rounded [3];
   logic [tfn_pkg::OUT_W-1:0] qmag [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = tfn_pkg::MUL_W'(rc_side[RC_STEPS].c[i])
                    * tfn_pkg::MUL_W'(rc_work[RC_STEPS].quot);
         rounded[i] = (tfn_pkg::MUL_W+1)'(prod_ff[i])
                    + ((tfn_pkg::MUL_W+1)'(1) << (tfn_pkg::OUT_SHIFT - 1));
         qmag[i]    = rounded[i][tfn_pkg::OUT_SHIFT +: tfn_pkg::OUT_W];
         if (degm_ff) begin
            rsp_n_in[i] = '0;
         end else if (negm_ff[i]) begin
            rsp_n_in[i] = tfn_pkg::OUT_W'(0) - qmag[i];
         end else begin
            rsp_n_in[i] = qmag[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mv_ff        <= rc_valid[RC_STEPS];
         rsp_valid_ff <= mv_ff;
      end
      for (int i = 0; i < 3; i++) begin
         prod_ff[i]  <= prod_in[i];
         rsp_n_ff[i] <= rsp_n_in[i];
      end
      negm_ff    <= rc_side[RC_STEPS].neg;
      degm_ff    <= rc_side[RC_STEPS].degenerate;
      rsp_deg_ff <= degm_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = rsp_n_ff[0];
   assign rsp_normal_y   = rsp_n_ff[1];
   assign rsp_normal_z   = rsp_n_ff[2];
   assign rsp_degenerate = rsp_deg_ff;

   // A degenerate beat always carries the zero vector.
   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate beat with non-zero normal");

   // A proper triangle leaves the root with its top bit pair populated,
   // since the largest normalised component has exactly NB bits.
   a_root_range : assert property (@(posedge clock) disable iff (reset)
      sq_valid[SQ_STEPS] && !sq_side[SQ_STEPS].degenerate |->
         sq_work[SQ_STEPS].root[tfn_pkg::ROOT_W-1 -: 2] != 2'b00)
      else $error("square root below the normalised range");

   // Every component of a proper normal stays within one unit.
   a_unit_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         $signed(rsp_normal_x) <= tfn_pkg::UNIT && $signed(rsp_normal_x) >= -tfn_pkg::UNIT
      && $signed(rsp_normal_y) <= tfn_pkg::UNIT && $signed(rsp_normal_y) >= -tfn_pkg::UNIT
      && $signed(rsp_normal_z) <= tfn_pkg::UNIT && $signed(rsp_normal_z) >= -tfn_pkg::UNIT)
      else $error("normal component beyond one unit");

endmodule
